@@ rtl/core/urr_pkg.sv @@
// Shared types and constants for the serial receive ring.
package urr_pkg;

  // Item codes
  typedef enum logic [1:0] {
    OpByte    = 2'd0,
    OpPop     = 2'd1,
    OpError   = 2'd2,
    OpService = 2'd3
  } opcode_e;

  localparam logic [15:0] RetryResetMs = 16'd10;

  // Status that the control logic presents to the result ports
  typedef struct packed {
    logic [31:0] overflow_total;
    logic [31:0] error_total;
    logic        receiving;
    logic        suspended;
  } status_t;

endpackage

@@ rtl/core/urr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module urr_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/urr_ctrl.sv @@
// Ring pointers, counters, receiver arm and retry state, and RAM access control.
module urr_ctrl #(
  parameter int RingDepth = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         accept_i,
  input  urr_pkg::opcode_e             opcode_i,
  input  logic [31:0]                  now_ms_i,
  input  logic                         enabled_i,
  output logic                         ram_we_o,
  output logic [$clog2(RingDepth)-1:0] ram_waddr_o,
  output logic                         ram_re_o,
  output logic [$clog2(RingDepth)-1:0] ram_raddr_o,
  output logic                         pop_valid_o,
  output urr_pkg::status_t             status_o
);

  localparam int IdxW = $clog2(RingDepth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RingDepth - 1);

  logic [15:0]     interval_q;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [31:0]     ovf_q, ovf_d, err_q, err_d, deadline_q, deadline_d;
  logic            waiting_q, waiting_d, held_q, held_d, armed_q, armed_d;
  logic            pop_valid_q, pop_valid_d;
  logic [IdxW-1:0] wr_next, rd_next;
  logic [31:0]     since_deadline;

  assign wr_next = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + 1'b1;
  assign rd_next = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
  assign since_deadline = now_ms_i - deadline_q;

  always_comb begin
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    ovf_d       = ovf_q;
    err_d       = err_q;
    deadline_d  = deadline_q;
    waiting_d   = waiting_q;
    held_d      = held_q;
    armed_d     = armed_q;
    pop_valid_d = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    if (accept_i) begin
      unique case (opcode_i)
        urr_pkg::OpByte: begin
          if (armed_q) begin
            if (wr_next == rd_idx_q) begin
              ovf_d = ovf_q + 32'd1;
            end else begin
              ram_we_o = 1'b1;
              wr_idx_d = wr_next;
            end
            waiting_d = 1'b0;
          end
        end
        urr_pkg::OpPop: begin
          if (rd_idx_q != wr_idx_q) begin
            ram_re_o    = 1'b1;
            pop_valid_d = 1'b1;
            rd_idx_d    = rd_next;
          end
        end
        urr_pkg::OpError: begin
          if (armed_q) begin
            err_d      = err_q + 32'd1;
            armed_d    = 1'b0;
            waiting_d  = 1'b1;
            deadline_d = now_ms_i + {16'd0, interval_q};
          end
        end
        urr_pkg::OpService: begin
          if (!enabled_i) begin
            if (!held_q) begin
              armed_d   = 1'b0;
              held_d    = 1'b1;
              waiting_d = 1'b1;
            end
          end else begin
            if (held_q) begin
              held_d     = 1'b0;
              deadline_d = now_ms_i;
            end
            // Leaving suspension puts the deadline at now, so it is reached at once
            if (waiting_q && (held_q || !since_deadline[31])) begin
              armed_d   = 1'b1;
              waiting_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= urr_pkg::RetryResetMs;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      ovf_q       <= '0;
      err_q       <= '0;
      deadline_q  <= '0;
      waiting_q   <= 1'b0;
      held_q      <= 1'b0;
      armed_q     <= 1'b1;
      pop_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      ovf_q       <= ovf_d;
      err_q       <= err_d;
      deadline_q  <= deadline_d;
      waiting_q   <= waiting_d;
      held_q      <= held_d;
      armed_q     <= armed_d;
      pop_valid_q <= pop_valid_d;
    end
  end

  assign ram_waddr_o = wr_idx_q;
  assign ram_raddr_o = rd_idx_q;
  assign pop_valid_o = pop_valid_q;

  assign status_o.overflow_total = ovf_q;
  assign status_o.error_total    = err_q;
  assign status_o.receiving      = armed_q;
  assign status_o.suspended      = held_q;

endmodule

@@ rtl/core/uart_receive_ring_with_error_retry_unit.sv @@
// Top level of the serial receive ring with line-error retry and suspend.
// Each item's result appears on done_o in the cycle after start_i is taken.
// Throughput: one item per cycle; busy_o stays low, the ring RAM does at most one access.
// A pop reads the ring RAM at acceptance; its registered read data forms pop_byte_o.
// Reset (rst_ni low, asynchronous) empties the ring, clears counters, arms the receiver
// and loads a 10 ms retry interval; RAM contents are left as they are.
// The receiver cannot stall: it must take each result in the cycle shown; not enforced.
module uart_receive_ring_with_error_retry_unit #(
  parameter int RING_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] now_ms_i,
  input  logic        enabled_i,
  output logic        done_o,
  output logic        pop_valid_o,
  output logic [7:0]  pop_byte_o,
  output logic [31:0] overflow_total_o,
  output logic [31:0] error_total_o,
  output logic        receiving_o,
  output logic        is_suspended_o
);

  localparam int IdxW = $clog2(RING_DEPTH);

  logic             accept;
  logic             done_q;
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata;
  logic             pop_valid;
  urr_pkg::status_t status;

  // Every item completes in one step, so never hold off the sender
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  urr_ctrl #(
    .RingDepth (RING_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .opcode_i    (urr_pkg::opcode_e'(opcode_i)),
    .now_ms_i    (now_ms_i),
    .enabled_i   (enabled_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .pop_valid_o (pop_valid),
    .status_o    (status)
  );

  // Byte ring: write at the write index, read at the read index
  urr_ram #(
    .Width (8),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result strobe: registered, high in the cycle after each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  assign done_o           = done_q;
  assign pop_valid_o      = pop_valid;
  // Drop stale read data unless this item returned a byte
  assign pop_byte_o       = pop_valid ? ram_rdata : 8'd0;
  assign overflow_total_o = status.overflow_total;
  assign error_total_o    = status.error_total;
  assign receiving_o      = status.receiving;
  assign is_suspended_o   = status.suspended;

`ifndef NO_ASSERTIONS
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("result strobe missing after accepted item");
  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("result strobe without accepted item");
  a_pop_valid_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid_o |-> done_o) else $error("pop valid outside a result");
  a_suspended_not_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_suspended_o |-> !receiving_o) else $error("receiver armed while suspended");
  a_overflow_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_total_o != $past(overflow_total_o) |-> done_o)
    else $error("overflow count moved without an item");
`endif

endmodule

@@ tb/tb_uart_receive_ring_with_error_retry_unit.sv @@
// Self-checking testbench for the serial receive ring with line-error retry and suspend.
module tb_uart_receive_ring_with_error_retry_unit;

  localparam int RingSlots  = 128;
  localparam int StallLimit = 2000;

  // One result as the block should show it
  typedef struct packed {
    logic             pop_valid;
    logic [7:0]       pop_byte;
    urr_pkg::status_t status;
  } ring_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        start_i     = 1'b0;
  logic [1:0]  opcode_i    = urr_pkg::OpPop;
  logic [7:0]  rx_byte_i   = '0;
  logic [31:0] now_ms_i    = '0;
  logic        enabled_i   = 1'b0;
  logic        busy_o;
  logic        done_o;
  logic        pop_valid_o;
  logic [7:0]  pop_byte_o;
  logic [31:0] overflow_total_o;
  logic [31:0] error_total_o;
  logic        receiving_o;
  logic        is_suspended_o;

  uart_receive_ring_with_error_retry_unit #(
    .RING_DEPTH(RingSlots)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .rx_byte_i       (rx_byte_i),
    .now_ms_i        (now_ms_i),
    .enabled_i       (enabled_i),
    .done_o          (done_o),
    .pop_valid_o     (pop_valid_o),
    .pop_byte_o      (pop_byte_o),
    .overflow_total_o(overflow_total_o),
    .error_total_o   (error_total_o),
    .receiving_o     (receiving_o),
    .is_suspended_o  (is_suspended_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: the ring, its pointers, counters and the retry/suspend flags
  logic [7:0]  ring_mem [RingSlots];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  logic [31:0] drop_count;
  logic [31:0] fault_count;
  logic        rearm_waiting;
  logic        suspended_q;
  logic        armed_q;
  logic [31:0] rearm_deadline;
  logic [15:0] retry_ms;

  ring_result_t status_due_q [$];
  int           mismatches  = 0;
  int           stall_count = 0;
  bit           burst_mode  = 1'b0;
  logic [31:0]  clock_ms    = '0;

  function automatic void reset_model();
    wr_ptr         = 0;
    rd_ptr         = 0;
    drop_count     = '0;
    fault_count    = '0;
    rearm_waiting  = 1'b0;
    suspended_q    = 1'b0;
    armed_q        = 1'b1;
    rearm_deadline = '0;
    retry_ms       = urr_pkg::RetryResetMs;
  endfunction

  // Advance the predictor by one accepted item and return what the block should report
  function automatic ring_result_t apply_ring_item(urr_pkg::opcode_e op, logic [7:0] data,
                                                   logic [31:0] now, logic en);
    ring_result_t res;
    int unsigned  nxt;
    logic [31:0]  lag;
    res = '0;
    case (op)
      urr_pkg::OpByte: begin
        if (armed_q) begin
          nxt = (wr_ptr + 1) % RingSlots;
          if (nxt == rd_ptr) begin
            drop_count++;
          end else begin
            ring_mem[wr_ptr] = data;
            wr_ptr = nxt;
          end
          rearm_waiting = 1'b0;
        end
      end
      urr_pkg::OpPop: begin
        if (rd_ptr != wr_ptr) begin
          res.pop_valid = 1'b1;
          res.pop_byte  = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % RingSlots;
        end
      end
      urr_pkg::OpError: begin
        if (armed_q) begin
          fault_count++;
          armed_q        = 1'b0;
          rearm_waiting  = 1'b1;
          rearm_deadline = now + {16'd0, retry_ms};
        end
      end
      urr_pkg::OpService: begin
        if (!en) begin
          if (!suspended_q) begin
            armed_q       = 1'b0;
            suspended_q   = 1'b1;
            rearm_waiting = 1'b1;
          end
        end else begin
          if (suspended_q) begin
            suspended_q    = 1'b0;
            rearm_deadline = now;
          end
          // Signed wrap-around compare: reached when the lag is not negative
          lag = now - rearm_deadline;
          if (rearm_waiting && !lag[31]) begin
            armed_q       = 1'b1;
            rearm_waiting = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.status.overflow_total = drop_count;
    res.status.error_total    = fault_count;
    res.status.receiving      = armed_q;
    res.status.suspended      = suspended_q;
    return res;
  endfunction

  // Mostly back-to-back, sometimes a short pause, rarely a long one; none in burst mode
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Time: clock creeps, jumps now and then, aims service at deadline; bytes, pops random
  function automatic logic [31:0] pick_now(urr_pkg::opcode_e op);
    int r;
    clock_ms = clock_ms + $urandom_range(0, 20);
    if ($urandom_range(0, 99) < 5) clock_ms = $urandom();
    if (op == urr_pkg::OpService) begin
      r = $urandom_range(0, 99);
      if (r < 40) return rearm_deadline - 32'd3 + $urandom_range(0, 6);
      if (r < 45) return rearm_deadline + (r[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
    end
    if (op == urr_pkg::OpError || op == urr_pkg::OpService) return clock_ms;
    return $urandom();
  endfunction

  // Present one item, hold it until taken, then queue its predicted result
  task automatic send_item(urr_pkg::opcode_e op, logic [7:0] data, logic [31:0] now,
                           logic en);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    opcode_i  <= op;
    rx_byte_i <= data;
    now_ms_i  <= now;
    enabled_i <= en;
    do @(posedge clk_i); while (busy_o);
    status_due_q.push_back(apply_ring_item(op, data, now, en));
  endtask

  // Drop start and wait until every outstanding result has been shown
  task automatic hold_until_drained();
    start_i <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_retry_interval(logic [15:0] ms);
    hold_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    retry_ms = ms;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Suspend then resume: resuming sets the deadline to now, so the receiver re-arms
  task automatic make_armed();
    send_item(urr_pkg::OpService, 8'($urandom_range(0, 255)), clock_ms, 1'b0);
    send_item(urr_pkg::OpService, 8'($urandom_range(0, 255)), clock_ms, 1'b1);
  endtask

  // Walk through every item kind and each corner of the arm/suspend/retry logic
  task automatic test_directed_cases();
    burst_mode = 1'b0;
    send_item(urr_pkg::OpPop,     8'h3C, 32'h0000_0000, 1'b0);  // pop on an empty ring
    send_item(urr_pkg::OpByte,    8'h00, 32'h0000_0000, 1'b0);
    send_item(urr_pkg::OpByte,    8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_item(urr_pkg::OpPop,     8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_item(urr_pkg::OpPop,     8'h00, 32'h0000_0000, 1'b0);
    send_item(urr_pkg::OpPop,     8'h81, 32'h1234_5678, 1'b1);  // empty again
    send_item(urr_pkg::OpService, 8'h00, 32'h0000_0000, 1'b1);  // enable, no retry waiting
    send_item(urr_pkg::OpByte,    8'hA5, 32'h0000_0000, 1'b0);
    // Error near the top of the clock: deadline wraps round to 2
    send_item(urr_pkg::OpError,   8'h00, 32'hFFFF_FFF8, 1'b0);
    send_item(urr_pkg::OpByte,    8'h5A, 32'h0000_0001, 1'b1);  // disarmed: byte ignored
    send_item(urr_pkg::OpError,   8'hFF, 32'h0000_0001, 1'b1);  // disarmed: error ignored
    send_item(urr_pkg::OpService, 8'h00, 32'h0000_0001, 1'b1);  // one short of the deadline
    send_item(urr_pkg::OpService, 8'h00, 32'h0000_0002, 1'b1);  // deadline reached, re-arm
    send_item(urr_pkg::OpService, 8'h00, 32'h0000_0003, 1'b0);  // suspend
    send_item(urr_pkg::OpService, 8'h00, 32'h0000_0004, 1'b0);  // disable while suspended
    send_item(urr_pkg::OpByte,    8'h77, 32'h0000_0005, 1'b0);  // suspended: byte ignored
    send_item(urr_pkg::OpError,   8'h00, 32'h0000_0005, 1'b0);  // suspended: error ignored
    send_item(urr_pkg::OpService, 8'h00, 32'h8000_0000, 1'b1);  // resume re-arms at once
    send_item(urr_pkg::OpError,   8'h00, 32'h7FFF_FFFF, 1'b0);  // deadline 0x8000_0009
    send_item(urr_pkg::OpService, 8'h00, 32'h0000_0009, 1'b1);  // half the clock away
    send_item(urr_pkg::OpService, 8'h00, 32'h0000_0008, 1'b1);  // just under half: reached
    send_item(urr_pkg::OpPop,     8'h00, 32'hFFFF_FFFF, 1'b0);
    send_item(urr_pkg::OpPop,     8'hFF, 32'h0000_0000, 1'b1);
  endtask

  // Fill the ring to its limit, push past it, then drain it completely
  task automatic test_ring_overflow();
    burst_mode = 1'b0;
    make_armed();
    while (wr_ptr != rd_ptr) begin
      send_item(urr_pkg::OpPop, 8'($urandom_range(0, 255)), $urandom(), 1'b0);
    end
    repeat (RingSlots - 1) begin
      send_item(urr_pkg::OpByte, 8'($urandom_range(0, 255)), $urandom(),
                1'($urandom_range(0, 1)));
    end
    repeat (3) send_item(urr_pkg::OpByte, 8'($urandom_range(0, 255)), $urandom(), 1'b0);
    send_item(urr_pkg::OpPop, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
    // Take the freed slot, then find the ring full again and drop
    send_item(urr_pkg::OpByte, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
    send_item(urr_pkg::OpByte, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
    while (wr_ptr != rd_ptr) begin
      send_item(urr_pkg::OpPop, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
    end
    send_item(urr_pkg::OpPop, 8'($urandom_range(0, 255)), $urandom(), 1'b0);
  endtask

  // Random mix of items; the percentages steer the ring towards full or empty
  task automatic test_random_traffic(int count, int byte_pct, int pop_pct, int err_pct,
                                     bit gapless);
    int               r;
    urr_pkg::opcode_e op;
    logic             en;
    burst_mode = gapless;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < byte_pct) op = urr_pkg::OpByte;
      else if (r < byte_pct + pop_pct) op = urr_pkg::OpPop;
      else if (r < byte_pct + pop_pct + err_pct) op = urr_pkg::OpError;
      else op = urr_pkg::OpService;
      en = (op == urr_pkg::OpService) ? ($urandom_range(0, 99) < 85)
                                      : 1'($urandom_range(0, 1));
      send_item(op, 8'($urandom_range(0, 255)), pick_now(op), en);
    end
    burst_mode = 1'b0;
  endtask

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Compare every shown result with the oldest prediction
  always @(posedge clk_i) begin
    ring_result_t due;
    if (rst_ni && done_o) begin
      if (status_due_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, {31'd0, done_o});
      end else begin
        due = status_due_q.pop_front();
        if (pop_valid_o !== due.pop_valid) begin
          flag_mismatch("pop_valid", 32'(due.pop_valid), 32'(pop_valid_o));
        end
        if (pop_byte_o !== due.pop_byte) begin
          flag_mismatch("pop_byte", 32'(due.pop_byte), 32'(pop_byte_o));
        end
        if (overflow_total_o !== due.status.overflow_total) begin
          flag_mismatch("overflow_total", due.status.overflow_total, overflow_total_o);
        end
        if (error_total_o !== due.status.error_total) begin
          flag_mismatch("error_total", due.status.error_total, error_total_o);
        end
        if (receiving_o !== due.status.receiving) begin
          flag_mismatch("receiving", 32'(due.status.receiving), 32'(receiving_o));
        end
        if (is_suspended_o !== due.status.suspended) begin
          flag_mismatch("is_suspended", 32'(due.status.suspended), 32'(is_suspended_o));
        end
      end
    end
  end

  // Abort when nothing has been taken or shown for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_count = 0;
    end else begin
      stall_count++;
    end
    if (stall_count >= StallLimit) begin
      $display("uart_receive_ring_with_error_retry_unit verification failed");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_ring_overflow();
    test_random_traffic(200, 65, 20, 5, 1'b0);
    write_retry_interval(16'd0);
    test_random_traffic(200, 40, 40, 8, 1'b1);
    write_retry_interval(16'hFFFF);
    test_random_traffic(200, 40, 35, 8, 1'b0);
    write_retry_interval(16'($urandom_range(1, 65534)));
    test_random_traffic(200, 30, 50, 6, 1'b0);
    write_retry_interval(16'd1);
    test_random_traffic(200, 45, 35, 10, 1'b0);

    hold_until_drained();
    if (mismatches == 0) begin
      $display("uart_receive_ring_with_error_retry_unit verification clean");
    end else begin
      $display("uart_receive_ring_with_error_retry_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/urr_pkg.sv
rtl/core/urr_ram.sv
rtl/core/urr_ctrl.sv
rtl/core/uart_receive_ring_with_error_retry_unit.sv
tb/tb_uart_receive_ring_with_error_retry_unit.sv
